/* rtl/wwmc_pkg.sv */
`timescale 1ns / 1ps

package wwmc_pkg;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_PATTERN_LOW    = 2'd0,
        REG_PATTERN_HIGH   = 2'd1,
        REG_PATTERN_LENGTH = 2'd2
    } cfg_reg_t;

    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 64;
    localparam int PAT_LEN_W    = 5;
    localparam int CHAR_W       = 8;

    localparam int LINE_NUM_W   = 32;
    localparam int LINE_CNT_W   = 16;
    localparam int TOTAL_CNT_W  = 32;
    localparam int M_TDATA_W    = LINE_NUM_W + LINE_CNT_W + TOTAL_CNT_W;

    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    // One entry of the event queue: matches found for a beat, and whether
    // the beat closed its line.
    typedef struct packed {
        logic [1:0] hits;
        logic       eol;
    } ev_t;

    function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
        if (c >= 8'h41 && c <= 8'h5A) begin
            return c + 8'h20;
        end
        return c;
    endfunction

    function automatic logic is_boundary(input logic [CHAR_W-1:0] c);
        logic b;
        unique case (c)
            8'h00, // NUL
            8'h20, // space
            8'h09, // tab
            8'h0A, // newline
            8'h2E, // .
            8'h2C, // ,
            8'h21, // !
            8'h3F, // ?
            8'h3B, // ;
            8'h3A, // :
            8'h2D, // -
            8'h5F, // _
            8'h28, // (
            8'h29, // )
            8'h5B, // [
            8'h5D, // ]
            8'h22, // double quote
            8'h27, // single quote
            8'h2F: // /
                b = 1'b1;
            default: b = 1'b0;
        endcase
        return b;
    endfunction

endpackage

/* rtl/wwmc_front.sv */
`timescale 1ns / 1ps

module wwmc_front #(
    parameter int PATTERN_BYTES = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [wwmc_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [wwmc_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [wwmc_pkg::CHAR_W-1:0]           s_tdata,
    input  logic                                  s_tlast,
    output logic                                  push,
    output wwmc_pkg::ev_t                         push_ev,
    input  logic                                  q_full
);
    import wwmc_pkg::*;

    localparam int WIN_DEPTH = PATTERN_BYTES + 1;
    localparam int CIL_W     = $clog2(WIN_DEPTH + 1);
    localparam int LEN_W     = $clog2(PATTERN_BYTES + 1);

    typedef logic [CHAR_W-1:0] win_arr_t [WIN_DEPTH];
    typedef logic [CHAR_W-1:0] pat_arr_t [PATTERN_BYTES];

    logic [CFG_DATA_W-1:0]  pattern_low_reg;
    logic [CFG_DATA_W-1:0]  pattern_high_reg;
    logic [PAT_LEN_W-1:0]   pattern_length_reg;
    logic [2*CFG_DATA_W-1:0] pat_all;

    win_arr_t               win_reg;
    win_arr_t               win_next;
    logic [CIL_W-1:0]       cil_reg;
    logic [CIL_W-1:0]       cil_shift;
    logic [CIL_W-1:0]       cil_next;

    logic [LEN_W-1:0]       act_len;
    pat_arr_t               align;
    logic                   s_accept;
    logic                   hit_before;
    logic                   hit_at_end;

    // A candidate ends at entry 0 of the window; its whole-word end has
    // been checked by the caller.
    function automatic logic cand(input win_arr_t w, input logic [CIL_W-1:0] cnt,
                                  input logic [LEN_W-1:0] ln, input pat_arr_t al);
        logic eq;
        logic bnd;
        eq  = 1'b1;
        bnd = 1'b0;
        for (int j = 0; j < PATTERN_BYTES; j++) begin
            if (j < int'(ln) && fold_case(w[j]) != al[j]) begin
                eq = 1'b0;
            end
        end
        for (int k = 0; k < WIN_DEPTH; k++) begin
            if (k == int'(ln)) begin
                bnd = is_boundary(w[k]);
            end
        end
        return (ln != '0) && (cnt >= CIL_W'(ln)) && eq && ((cnt == CIL_W'(ln)) || bnd);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            pattern_length_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PATTERN_LOW:    pattern_low_reg    <= cfg_wdata;
                REG_PATTERN_HIGH:   pattern_high_reg   <= cfg_wdata;
                REG_PATTERN_LENGTH: pattern_length_reg <= cfg_wdata[PAT_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign pat_all = {pattern_high_reg, pattern_low_reg};

    always_comb begin
        if (pattern_length_reg > PAT_LEN_W'(PATTERN_BYTES)) begin
            act_len = LEN_W'(PATTERN_BYTES);
        end else begin
            act_len = LEN_W'(pattern_length_reg);
        end
    end

    // Pattern reversed so that its last byte lines up with window entry 0.
    always_comb begin
        for (int j = 0; j < PATTERN_BYTES; j++) begin
            align[j] = '0;
            for (int i = 0; i < PATTERN_BYTES; i++) begin
                if (i + j + 1 == int'(act_len)) begin
                    align[j] = fold_case(pat_all[CHAR_W*i +: CHAR_W]);
                end
            end
        end
    end

    always_comb begin
        win_next[0] = s_tdata;
        for (int k = 1; k < WIN_DEPTH; k++) begin
            win_next[k] = win_reg[k-1];
        end
        cil_shift = (cil_reg == CIL_W'(WIN_DEPTH)) ? cil_reg : cil_reg + 1'b1;
        cil_next  = s_tlast ? '0 : cil_shift;
    end

    assign s_tready   = !q_full;
    assign s_accept   = s_tvalid && s_tready;
    assign hit_before = is_boundary(s_tdata) && cand(win_reg, cil_reg, act_len, align);
    assign hit_at_end = s_tlast && cand(win_next, cil_shift, act_len, align);

    assign push_ev.hits = {1'b0, hit_before} + {1'b0, hit_at_end};
    assign push_ev.eol  = s_tlast;
    assign push         = s_accept && (hit_before || hit_at_end || s_tlast);

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            win_reg <= win_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cil_reg <= '0;
        end else if (s_accept) begin
            cil_reg <= cil_next;
        end
    end

    a_line_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_tlast |=> cil_reg == '0)
        else $error("byte count not cleared after line end");

    a_eol_pushed: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_tlast |-> push && push_ev.eol)
        else $error("line end beat did not reach the queue");

endmodule

/* rtl/wwmc_queue.sv */
`timescale 1ns / 1ps

module wwmc_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  wwmc_pkg::ev_t  push_ev,
    output logic           full,
    input  logic           pop,
    output wwmc_pkg::ev_t  pop_ev,
    output logic           empty
);
    import wwmc_pkg::*;

    ev_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_ev  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_ev;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("event pushed into a full queue");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

/* rtl/wwmc_back.sv */
`timescale 1ns / 1ps

module wwmc_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  wwmc_pkg::ev_t                     pop_ev,
    input  logic                              empty,
    output logic                              pop,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [wwmc_pkg::M_TDATA_W-1:0]    m_tdata
);
    import wwmc_pkg::*;

    logic [LINE_CNT_W-1:0]  line_matches_reg;
    logic [LINE_CNT_W-1:0]  line_matches_next;
    logic [TOTAL_CNT_W-1:0] matches_total_reg;
    logic [TOTAL_CNT_W-1:0] matches_total_next;
    logic [LINE_NUM_W-1:0]  lines_done_reg;
    logic [LINE_NUM_W-1:0]  lines_done_next;
    logic [LINE_CNT_W:0]    line_sum;
    logic [TOTAL_CNT_W:0]   total_sum;
    logic                   m_tvalid_reg;
    logic [M_TDATA_W-1:0]   m_tdata_reg;
    logic                   load_out;

    // A line end needs the output register free; other events never wait.
    assign pop      = !empty && (!pop_ev.eol || !m_tvalid_reg || m_tready);
    assign load_out = pop && pop_ev.eol;

    always_comb begin
        line_sum  = {1'b0, line_matches_reg} + (LINE_CNT_W + 1)'(pop_ev.hits);
        total_sum = {1'b0, matches_total_reg} + (TOTAL_CNT_W + 1)'(pop_ev.hits);
        line_matches_next  = line_sum[LINE_CNT_W] ? '1 : line_sum[LINE_CNT_W-1:0];
        matches_total_next = total_sum[TOTAL_CNT_W] ? '1 : total_sum[TOTAL_CNT_W-1:0];
        lines_done_next    = (lines_done_reg == '1) ? lines_done_reg
                                                    : lines_done_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_matches_reg  <= '0;
            matches_total_reg <= '0;
            lines_done_reg    <= '0;
        end else if (pop) begin
            matches_total_reg <= matches_total_next;
            if (pop_ev.eol) begin
                line_matches_reg <= '0;
                lines_done_reg   <= lines_done_next;
            end else begin
                line_matches_reg <= line_matches_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_tdata_reg <= {matches_total_next, line_matches_next, lines_done_next};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_line_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> line_matches_reg == '0 && m_tvalid_reg)
        else $error("line end did not clear the line count or raise a result");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |-> !m_tvalid_reg || m_tready)
        else $error("result register overwritten before it was taken");

endmodule

/* rtl/whole_word_match_counter_top.sv */
`timescale 1ns / 1ps

// Channel  Direction  Beat contents
// cfg      in         cfg_index selects register, cfg_wdata is the value
// s_       in         one text byte; tlast marks the last byte of a line
// m_       out        one result per line: number, line matches, total
//
// One text byte is taken every cycle while s_tready is high; the window
// compare is done in the same cycle as the byte is accepted. A line result
// passes from its accepted last byte through the four-entry event queue
// into the output register. Reset is synchronous and clears the pattern,
// the counters and the queue. s_tready drops only when the event queue is
// full, which happens when line results are held back by m_tready.
module whole_word_match_counter_top #(
    parameter int PATTERN_BYTES = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [wwmc_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [wwmc_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [wwmc_pkg::CHAR_W-1:0]           s_tdata,   // char_code[7:0]
    input  logic                                  s_tlast,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // line_number[31:0], line_count[47:32], total_count[79:48]
    output logic [wwmc_pkg::M_TDATA_W-1:0]        m_tdata
);
    import wwmc_pkg::*;

    logic push;
    ev_t  push_ev;
    logic q_full;
    logic pop;
    ev_t  pop_ev;
    logic q_empty;

    wwmc_front #(
        .PATTERN_BYTES (PATTERN_BYTES)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .push      (push),
        .push_ev   (push_ev),
        .q_full    (q_full)
    );

    wwmc_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .push_ev (push_ev),
        .full    (q_full),
        .pop     (pop),
        .pop_ev  (pop_ev),
        .empty   (q_empty)
    );

    wwmc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .pop_ev   (pop_ev),
        .empty    (q_empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import wwmc_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int WIN_DEPTH    = 17;
    localparam int MAX_PAT      = 16;
    localparam int DRAIN_CYCLES = 6;
    localparam int RANDOM_BEATS = 800;
    localparam int PHASE_BEATS  = 70;

    typedef struct {
        logic [LINE_NUM_W-1:0]  line_no;
        logic [LINE_CNT_W-1:0]  hits;
        logic [TOTAL_CNT_W-1:0] total;
    } line_result_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [CHAR_W-1:0]      s_tdata;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;

    whole_word_match_counter_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Shadow of the block: pattern registers and per-line scan state.
    logic [63:0]       pat_lo;
    logic [63:0]       pat_hi;
    logic [4:0]        pat_len;
    logic [7:0]        window [WIN_DEPTH];
    int                chars_seen;
    logic [15:0]       line_hits;
    logic [31:0]       lines_done;
    logic [31:0]       total_hits;
    line_result_t      line_results_q [$];

    logic [7:0]        line_buf [$];
    int                chain_ulen;
    bit                tx_gaps_on;
    bit                rx_gaps_on;
    int                rx_hold_left;
    int                beats_sent;
    int                lines_sent;
    int                results_checked;
    int                fail_count;
    int                tx_stall_cycles;

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("tb_top: timeout");
        $display("tb_top: done, errors");
        $finish;
    end

    function automatic logic [7:0] lower_ascii(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A) begin
            return c | 8'h20;
        end
        return c;
    endfunction

    function automatic bit is_word_break(input logic [7:0] c);
        return c inside {8'h00, 8'h09, 8'h0A, 8'h20, 8'h21, 8'h22, 8'h27, 8'h28, 8'h29,
                         8'h2C, 8'h2D, 8'h2E, 8'h2F, 8'h3A, 8'h3B, 8'h3F, 8'h5B, 8'h5D,
                         8'h5F};
    endfunction

    function automatic logic [7:0] pattern_byte(input int i);
        if (i < 8) begin
            return pat_lo[8*i +: 8];
        end
        return pat_hi[8*(i-8) +: 8];
    endfunction

    function automatic int active_len();
        return (pat_len > MAX_PAT) ? MAX_PAT : int'(pat_len);
    endfunction

    // True when the pattern ends at the newest window byte and starts a word.
    function automatic bit word_ends_here();
        int len;
        len = active_len();
        if (len == 0 || chars_seen < len) begin
            return 1'b0;
        end
        for (int i = 0; i < len; i++) begin
            if (lower_ascii(window[len-1-i]) != lower_ascii(pattern_byte(i))) begin
                return 1'b0;
            end
        end
        if (chars_seen == len) begin
            return 1'b1;
        end
        return is_word_break(window[len]);
    endfunction

    function automatic void count_hit();
        if (line_hits != 16'hFFFF) begin
            line_hits++;
        end
        if (total_hits != 32'hFFFF_FFFF) begin
            total_hits++;
        end
    endfunction

    function automatic void clear_line();
        foreach (window[k]) begin
            window[k] = 8'h00;
        end
        chars_seen = 0;
        line_hits  = 16'h0000;
    endfunction

    function automatic void scan_char(input logic [7:0] c, input logic eol);
        line_result_t r;
        if (is_word_break(c) && word_ends_here()) begin
            count_hit();
        end
        for (int k = WIN_DEPTH - 1; k > 0; k--) begin
            window[k] = window[k-1];
        end
        window[0] = c;
        if (chars_seen < WIN_DEPTH) begin
            chars_seen++;
        end
        if (eol) begin
            // The line end closes a word just like a boundary byte does.
            if (word_ends_here()) begin
                count_hit();
            end
            if (lines_done != 32'hFFFF_FFFF) begin
                lines_done++;
            end
            r.line_no = lines_done;
            r.hits    = line_hits;
            r.total   = total_hits;
            line_results_q.push_back(r);
            clear_line();
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end
        if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(12, 40);
    endfunction

    function automatic logic [7:0] random_letter();
        if ($urandom_range(0, 1) != 0) begin
            return 8'($urandom_range(8'h61, 8'h7A));
        end
        return 8'($urandom_range(8'h41, 8'h5A));
    endfunction

    function automatic logic [7:0] vary_case(input logic [7:0] c);
        if (((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A))
                && $urandom_range(0, 1) != 0) begin
            return c ^ 8'h20;
        end
        return c;
    endfunction

    function automatic logic [7:0] pick_break();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(1, 255));
        end while (!is_word_break(b));
        return b;
    endfunction

    function automatic logic [127:0] pack_text(input string s);
        logic [127:0] r;
        r = '0;
        for (int i = 0; i < s.len() && i < MAX_PAT; i++) begin
            r[8*i +: 8] = s[i];
        end
        return r;
    endfunction

    // Receiver: random stalls, plus a long hold-off that a test can request.
    initial begin
        int stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                stall_left = rx_gaps_on ? pick_gap() : 0;
                m_tready <= (stall_left == 0);
                if (stall_left > 0) begin
                    stall_left--;
                end
            end
        end
    end

    task automatic note_failure(input string what, input logic [31:0] line_no,
                                input logic [31:0] want, input logic [31:0] got);
        fail_count++;
        if (fail_count <= 10) begin
            $display("tb_top: %s mismatch, line %0d: expected %0d, got %0d",
                     what, line_no, want, got);
        end
    endtask

    always @(posedge aclk) begin
        line_result_t got;
        line_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.line_no = m_tdata[LINE_NUM_W-1:0];
            got.hits    = m_tdata[LINE_NUM_W +: LINE_CNT_W];
            got.total   = m_tdata[LINE_NUM_W+LINE_CNT_W +: TOTAL_CNT_W];
            results_checked++;
            if (line_results_q.size() == 0) begin
                note_failure("unexpected result", got.line_no, '0, got.line_no);
            end else begin
                want = line_results_q.pop_front();
                if (got.line_no !== want.line_no) begin
                    note_failure("line_number", want.line_no, want.line_no, got.line_no);
                end
                if (got.hits !== want.hits) begin
                    note_failure("line_count", want.line_no, 32'(want.hits), 32'(got.hits));
                end
                if (got.total !== want.total) begin
                    note_failure("total_count", want.line_no, want.total, got.total);
                end
            end
        end
    end

    task automatic write_reg(input cfg_reg_t idx, input logic [63:0] value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_PATTERN_LOW:    pat_lo  = value;
            REG_PATTERN_HIGH:   pat_hi  = value;
            REG_PATTERN_LENGTH: pat_len = value[4:0];
            default: ;
        endcase
    endtask

    task automatic program_pattern(input logic [127:0] bytes_in, input logic [4:0] len);
        write_reg(REG_PATTERN_LOW, bytes_in[63:0]);
        write_reg(REG_PATTERN_HIGH, bytes_in[127:64]);
        write_reg(REG_PATTERN_LENGTH, {59'd0, len});
    endtask

    task automatic send_beat(input logic [7:0] c, input logic eol);
        int gap;
        gap = tx_gaps_on ? pick_gap() : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eol;
        do begin
            @(posedge aclk);
            if (!s_tready) begin
                tx_stall_cycles++;
            end
        end while (!s_tready);
        beats_sent++;
        scan_char(c, eol);
    endtask

    task automatic send_line_buf();
        for (int i = 0; i < line_buf.size(); i++) begin
            send_beat(line_buf[i], i == line_buf.size() - 1);
        end
        lines_sent++;
    endtask

    task automatic text_line(input string s);
        line_buf.delete();
        for (int i = 0; i < s.len(); i++) begin
            line_buf.push_back(s[i]);
        end
        send_line_buf();
    endtask

    // Drop valid, wait for every pending line result, then let the pipe drain.
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (line_results_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic push_pattern_word();
        for (int i = 0; i < active_len(); i++) begin
            line_buf.push_back(vary_case(pattern_byte(i)));
        end
    endtask

    // Mostly pattern words and near misses separated by boundary bytes, with
    // some glued tokens and a few lines of plain noise.
    task automatic build_random_line();
        int ntok;
        int start;
        int reps;
        int n;
        line_buf.delete();
        if ($urandom_range(0, 19) == 0) begin
            n = $urandom_range(1, 12);
            repeat (n) line_buf.push_back(8'($urandom_range(1, 255)));
            return;
        end
        ntok = $urandom_range(1, 6);
        if ($urandom_range(0, 99) < 30) begin
            line_buf.push_back(pick_break());
        end
        for (int t = 0; t < ntok; t++) begin
            start = line_buf.size();
            n = $urandom_range(0, 99);
            if (n < 45) begin
                push_pattern_word();
            end else if (n < 55) begin
                if (chain_ulen > 0) begin
                    reps = $urandom_range(1, 3);
                    for (int r = 0; r <= reps; r++) begin
                        for (int i = 0; i < chain_ulen; i++) begin
                            line_buf.push_back(vary_case(pattern_byte(i)));
                        end
                        if (r < reps) begin
                            line_buf.push_back(pattern_byte(chain_ulen));
                        end
                    end
                end else begin
                    push_pattern_word();
                end
            end else if (n < 70) begin
                push_pattern_word();
                case ($urandom_range(0, 4))
                    0: if (line_buf.size() > start) void'(line_buf.pop_back());
                    1: if (line_buf.size() > start) line_buf.delete(start);
                    2: if (line_buf.size() > start) begin
                        line_buf[$urandom_range(start, line_buf.size() - 1)] = random_letter();
                    end
                    3: line_buf.push_back(random_letter());
                    default: line_buf.insert(start, random_letter());
                endcase
            end else if (n < 90) begin
                repeat ($urandom_range(1, 8)) begin
                    if ($urandom_range(0, 4) == 0) begin
                        line_buf.push_back(8'($urandom_range(8'h30, 8'h39)));
                    end else begin
                        line_buf.push_back(random_letter());
                    end
                end
            end else begin
                repeat ($urandom_range(1, 4)) line_buf.push_back(8'($urandom_range(1, 255)));
            end
            if (line_buf.size() == start) begin
                line_buf.push_back(random_letter());
            end
            if (t < ntok - 1 && $urandom_range(0, 99) < 85) begin
                repeat ($urandom_range(1, 2)) line_buf.push_back(pick_break());
            end
        end
        if ($urandom_range(0, 99) < 40) begin
            line_buf.push_back(pick_break());
        end
    endtask

    task automatic test_directed();
        logic [127:0] pb;
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
        program_pattern(pack_text("aB"), 5'd2);
        text_line("ab");
        text_line("(AB)");
        text_line("xab");
        line_buf = '{8'h01, 8'hFF};
        send_line_buf();
        // A NUL text byte acts as a word boundary.
        line_buf = '{8'h00, 8'h61, 8'h62};
        send_line_buf();
        settle();
        program_pattern(pack_text("a a"), 5'd3);
        text_line("a a a");
        settle();
        // A length above the pattern size is clipped to the full pattern.
        program_pattern(pack_text("abcdefghijklmnop"), 5'd31);
        text_line("ABCDEFGHIJKLMNOP");
        settle();
        pb = pack_text("a_b");
        pb[15:8] = 8'h00;
        program_pattern(pb, 5'd3);
        line_buf = '{8'h61, 8'h00, 8'h62};
        send_line_buf();
        text_line("a b");
        settle();
    endtask

    task automatic test_backpressure();
        program_pattern(pack_text("go"), 5'd2);
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        @(posedge aclk);
        rx_hold_left = 150;
        for (int n = 0; n < 30; n++) begin
            if (n % 3 == 0) begin
                text_line("go");
            end else begin
                text_line("x");
            end
        end
        settle();
    endtask

    task automatic test_random_text();
        int           phase;
        int           mark;
        int           phase_start;
        int           len;
        int           ulen;
        logic [7:0]   b;
        logic [127:0] pb;
        logic [4:0]   len_reg;
        phase = 0;
        mark  = beats_sent;
        while (beats_sent - mark < RANDOM_BEATS) begin
            chain_ulen = 0;
            // Bytes past the active length are random and must be ignored.
            for (int i = 0; i < MAX_PAT; i++) begin
                pb[8*i +: 8] = 8'($urandom_range(0, 255));
            end
            case (phase % 10)
                0: len_reg = 5'd0;
                1: begin
                    pb[7:0] = random_letter();
                    len_reg = 5'd1;
                end
                2, 3: begin
                    for (int i = 0; i < MAX_PAT; i++) begin
                        pb[8*i +: 8] = random_letter();
                    end
                    len_reg = (phase % 10 == 2) ? 5'd16 : 5'($urandom_range(17, 31));
                end
                4, 7: begin
                    len = (phase % 10 == 4) ? $urandom_range(2, 8) : $urandom_range(1, 16);
                    for (int i = 0; i < len; i++) begin
                        pb[8*i +: 8] = random_letter();
                        if (phase % 10 == 7) begin
                            pb[8*i + 5] = 1'b0;
                        end
                    end
                    len_reg = 5'(len);
                end
                5: begin
                    // Word, boundary, same word: chained copies overlap.
                    ulen = $urandom_range(1, 2);
                    for (int i = 0; i < ulen; i++) begin
                        pb[8*i +: 8]          = random_letter();
                        pb[8*(ulen+1+i) +: 8] = pb[8*i +: 8];
                    end
                    pb[8*ulen +: 8] = pick_break();
                    chain_ulen = ulen;
                    len_reg = 5'(2 * ulen + 1);
                end
                6: begin
                    len = $urandom_range(1, 16);
                    for (int i = 0; i < len; i++) begin
                        do begin
                            b = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(128, 255))
                                                            : 8'($urandom_range(1, 127));
                        end while (is_word_break(b));
                        pb[8*i +: 8] = b;
                    end
                    len_reg = 5'(len);
                end
                8: begin
                    pb      = '1;
                    len_reg = 5'd16;
                end
                default: begin
                    len = $urandom_range(2, 6);
                    for (int i = 0; i < len; i++) begin
                        pb[8*i +: 8] = random_letter();
                    end
                    pb[8*$urandom_range(0, len - 1) +: 8] = 8'h00;
                    len_reg = 5'(len);
                end
            endcase
            program_pattern(pb, len_reg);
            tx_gaps_on  = ($urandom_range(0, 3) != 0);
            rx_gaps_on  = ($urandom_range(0, 3) != 0);
            phase_start = beats_sent;
            while (beats_sent - phase_start < PHASE_BEATS) begin
                build_random_line();
                send_line_buf();
            end
            settle();
            phase++;
        end
    endtask

    initial begin
        aresetn         = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = REG_PATTERN_LOW;
        cfg_wdata       = '0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tlast         = 1'b0;
        tx_gaps_on      = 1'b0;
        rx_gaps_on      = 1'b0;
        rx_hold_left    = 0;
        chain_ulen      = 0;
        beats_sent      = 0;
        lines_sent      = 0;
        results_checked = 0;
        fail_count      = 0;
        tx_stall_cycles = 0;
        pat_lo          = '0;
        pat_hi          = '0;
        pat_len         = '0;
        lines_done      = '0;
        total_hits      = '0;
        clear_line();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_backpressure();
        test_random_text();

        $display("tb_top: %0d text beats in %0d lines, %0d line results checked",
                 beats_sent, lines_sent, results_checked);
        $display("tb_top: pattern lengths 0 to 31, mixed case, %0d input stall cycles",
                 tx_stall_cycles);
        if (fail_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/wwmc_pkg.sv
rtl/wwmc_front.sv
rtl/wwmc_queue.sv
rtl/wwmc_back.sv
rtl/whole_word_match_counter_top.sv
test/tb_top.sv
